>>> design/tccs_pkg.sv
// Shared constants, types and helpers for the text console cursor/scroll unit.
// No dependencies.
`default_nettype none

package tccs_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CELL_W  = 16;

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);
    // First cell of the bottom row; also the number of cells moved by a scroll.
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Register select bit of the config port (word index).
    localparam logic REG_TEXT_COLOR = 1'b0;

    typedef struct packed {
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
        logic       scrolled;
    } t_result;

    typedef struct packed {
        logic clearing;
        logic scrolling;
    } t_status;

    function automatic logic [ADDR_W-1:0] cell_addr(input int row, input int col);
        return ADDR_W'(row * COLUMNS + col);
    endfunction

endpackage

`default_nettype wire

>>> design/text_console_cursor_scroll_unit.sv
// Top level of the text console: config register, cell RAM, sequencer and
// result register. Depends on tccs_pkg, tccs_ram, tccs_seq.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  input    | i_in_valid / o_in_ready    | i_mode, i_char_code, i_read_column, i_read_row
//  output   | o_out_valid / i_out_ready  | o_cursor_column, o_cursor_row, o_cell_char,
//           |                            | o_cell_color, o_scrolled
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// A put passes the EXEC state, a read also the READ state for the registered RAM
// read. A put that scrolls then passes the COPY and FILL states: the single RAM
// write port moves one cell per cycle, then fills the bottom row. After reset a
// clearing pass writes every cell once before input is taken. One item is in
// work at a time; the next can be taken while a result waits.
`default_nettype none

module text_console_cursor_scroll_unit
    import tccs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [6:0]  i_read_column,
    input  wire logic [4:0]  i_read_row,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [6:0]       o_cursor_column,
    output logic [4:0]       o_cursor_row,
    output logic [7:0]       o_cell_char,
    output logic [7:0]       o_cell_color,
    output logic             o_scrolled,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]        r_text_color;
    logic              r_out_valid;
    t_result           r_out;

    logic              res_valid;
    logic              res_ready;
    logic              res_load;
    t_result           res;
    t_status           status;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_COLOR);
    assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, r_text_color} : 32'd0;

    tccs_ram #(
        .DEPTH  (CELLS),
        .WIDTH  (CELL_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tccs_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_char_code   (i_char_code),
        .i_read_column (i_read_column),
        .i_read_row    (i_read_row),
        .i_text_color  (r_text_color),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_status      (status)
    );

    assign res_ready = !r_out_valid || i_out_ready;
    assign res_load  = res_valid && res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_COLOR;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_text_color <= pwdata[7:0];
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cursor_column = r_out.cursor_column;
    assign o_cursor_row    = r_out.cursor_row;
    assign o_cell_char     = r_out.cell_char;
    assign o_cell_color    = r_out.cell_color;
    assign o_scrolled      = r_out.scrolled;

    // One item at a time: no new transaction right after one is taken.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    a_no_input_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clearing |-> !o_in_ready)
        else $error("input ready during RAM clearing pass");

    a_scroll_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.scrolling |=> !o_in_ready)
        else $error("input ready straight after scroll step");

    // A scroll always leaves the cursor at the start of the bottom row.
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_load && res.scrolled) |->
            (res.cursor_column == 7'd0) && (res.cursor_row == 5'(ROWS - 1)))
        else $error("scroll result with cursor off the bottom row start");

endmodule

`default_nettype wire

>>> design/tccs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tccs_ram #(
    parameter int DEPTH  = 2000,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/tccs_seq.sv
// Sequencer: cursor state, character handling, scroll copy/fill and reset clear
// of the cell RAM. Depends on tccs_pkg.
`default_nettype none

module tccs_seq
    import tccs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_mode,
    input  wire logic [7:0]        i_char_code,
    input  wire logic [6:0]        i_read_column,
    input  wire logic [4:0]        i_read_row,
    input  wire logic [7:0]        i_text_color,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_result                o_res,
    output logic                   o_wr_en,
    output logic [ADDR_W-1:0]      o_wr_addr,
    output logic [CELL_W-1:0]      o_wr_data,
    output logic [ADDR_W-1:0]      o_rd_addr,
    input  wire logic [CELL_W-1:0] i_rd_data,
    output t_status                o_status
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_COPY,
        S_FILL,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_mode, n_mode;
    logic [7:0]        r_char, n_char;
    logic [6:0]        r_rcol, n_rcol;
    logic [4:0]        r_rrow, n_rrow;
    logic              r_rd_ok, n_rd_ok;
    t_result           r_res, n_res;

    logic [COL_W-1:0]  bs_col;
    logic [ROW_W-1:0]  bs_row;
    logic              do_scroll;

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_col     = r_col;
        n_row     = r_row;
        n_mode    = r_mode;
        n_char    = r_char;
        n_rcol    = r_rcol;
        n_rrow    = r_rrow;
        n_rd_ok   = r_rd_ok;
        n_res     = r_res;
        bs_col    = '0;
        bs_row    = '0;
        do_scroll = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_ptr;
        o_wr_data = {RESET_COLOR, CH_SPACE};
        o_rd_addr = '0;

        case (r_state)
            S_CLEAR: begin
                o_wr_en = 1'b1;
                if (r_ptr == ADDR_LAST) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_char  = i_char_code;
                    n_rcol  = i_read_column;
                    n_rrow  = i_read_row;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res = '0;
                if (r_mode == MODE_READ) begin
                    n_rd_ok   = (int'(r_rcol) < COLUMNS) && (int'(r_rrow) < ROWS);
                    o_rd_addr = cell_addr(int'(r_rrow), int'(r_rcol));
                    n_state   = S_READ;
                end else begin
                    if (r_char == CH_NEWLINE) begin
                        n_col = '0;
                        if (r_row == ROW_LAST) begin
                            do_scroll = 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else if (r_char == CH_BACKSPACE) begin
                        if (r_col != '0) begin
                            bs_col = r_col - 1'b1;
                            bs_row = r_row;
                        end else if (r_row != '0) begin
                            bs_col = COL_LAST;
                            bs_row = r_row - 1'b1;
                        end
                        n_col     = bs_col;
                        n_row     = bs_row;
                        o_wr_en   = 1'b1;
                        o_wr_addr = cell_addr(int'(bs_row), int'(bs_col));
                        o_wr_data = {i_text_color, CH_SPACE};
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = cell_addr(int'(r_row), int'(r_col));
                        o_wr_data = {i_text_color, r_char};
                        if (r_col == COL_LAST) begin
                            n_col = '0;
                            if (r_row == ROW_LAST) begin
                                do_scroll = 1'b1;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                    if (do_scroll) begin
                        n_col   = '0;
                        n_row   = ROW_LAST;
                        n_ptr   = '0;
                        n_state = S_COPY;
                    end else begin
                        n_state = S_DONE;
                    end
                    n_res.scrolled = do_scroll;
                end
                n_res.cursor_column = 7'(n_col);
                n_res.cursor_row    = 5'(n_row);
            end
            S_READ: begin
                if (r_rd_ok) begin
                    n_res.cell_char  = i_rd_data[7:0];
                    n_res.cell_color = i_rd_data[15:8];
                end
                n_state = S_DONE;
            end
            S_COPY: begin
                // Read one row ahead; write back what was read last cycle.
                if (r_ptr != COPY_END) begin
                    o_rd_addr = r_ptr + ROW_STEP;
                end
                o_wr_en   = (r_ptr != '0);
                o_wr_addr = r_ptr - 1'b1;
                o_wr_data = i_rd_data;
                if (r_ptr == COPY_END) begin
                    n_state = S_FILL;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_FILL: begin
                o_wr_en   = 1'b1;
                o_wr_data = {i_text_color, CH_SPACE};
                if (r_ptr == ADDR_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_col   <= n_col;
            r_row   <= n_row;
            r_rd_ok <= n_rd_ok;
        end
        r_mode <= n_mode;
        r_char <= n_char;
        r_rcol <= n_rcol;
        r_rrow <= n_rrow;
        r_res  <= n_res;
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_res_valid        = (r_state == S_DONE);
    assign o_res              = r_res;
    assign o_status.clearing  = (r_state == S_CLEAR);
    assign o_status.scrolling = (r_state == S_COPY) || (r_state == S_FILL);

endmodule

`default_nettype wire
